// ----- hdl/gbpi_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, register indexes and types of the pair-interleave packer.
package gbpi_pkg;

  localparam int MaxK       = 512;
  localparam int MaxN       = 4096;
  localparam int PanelWidth = 32;
  localparam int HalfPanel  = 16;
  localparam int RowW       = 10;
  localparam int ColW       = 13;
  localparam int OfsW       = 21;
  localparam int LaneW      = 64;
  localparam int ChunkW     = 128;
  localparam int JobW       = PanelWidth * 16;

  localparam logic [0:0] RegRowCount    = 1'b0;
  localparam logic [0:0] RegColumnCount = 1'b1;

  localparam logic [RowW-1:0] RowCountReset    = 10'd2;
  localparam logic [ColW-1:0] ColumnCountReset = 13'd32;

  localparam logic [6:0] PackedRowStride = 7'd64;
  localparam logic [5:0] PackedColStride = 6'd32;

  typedef struct packed {
    logic            restart;
    logic [RowW-1:0] rows;
    logic [ColW-1:0] cols;
  } cfg_t;

  typedef struct packed {
    logic [JobW-1:0] data;
    logic [OfsW-1:0] base;
    logic            wide;
    logic            done;
  } job_t;

endpackage

// ----- hdl/gbpi_front.sv -----
`timescale 1ns / 1ps
// Front end: tracks the row and panel position, holds even rows and forms row-pair jobs.
module gbpi_front (
  input  logic                         clk,
  input  logic                         rst,
  input  gbpi_pkg::cfg_t               cfg,
  input  logic                         push,
  output logic                         full,
  input  logic [gbpi_pkg::LaneW-1:0]   lane_bytes_0,
  input  logic [gbpi_pkg::LaneW-1:0]   lane_bytes_1,
  input  logic [gbpi_pkg::LaneW-1:0]   lane_bytes_2,
  input  logic [gbpi_pkg::LaneW-1:0]   lane_bytes_3,
  output gbpi_pkg::job_t               job,
  output logic                         job_push,
  input  logic                         job_full
);
  import gbpi_pkg::*;

  logic [RowW-1:0]          row_index, row_index_next;
  logic [ColW-1:0]          panel_start_col, panel_start_col_next;
  logic [PanelWidth-1:0][7:0] held_even_row;

  logic [RowW-1:0]          r;
  logic [ColW-1:0]          psc;
  logic [ColW-1:0]          rem;
  logic                     wide;
  logic [5:0]               valid;
  logic                     last_row;
  logic                     last_panel;
  logic                     emits;
  logic                     accept;
  logic [RowW-1:0]          k_even;
  logic [22:0]              product;
  logic [14:0]              row_term;
  logic [ColW:0]            col_sum;
  logic [PanelWidth*8-1:0]  row_bits;

  assign row_bits = {lane_bytes_3, lane_bytes_2, lane_bytes_1, lane_bytes_0};

  always_comb begin
    r        = (row_index >= cfg.rows) ? '0 : row_index;
    psc      = (panel_start_col >= cfg.cols) ? '0 : panel_start_col;
    rem      = cfg.cols - psc;
    wide     = rem >= ColW'(PanelWidth);
    if (wide) begin
      valid = 6'(PanelWidth);
    end else if (rem >= ColW'(HalfPanel)) begin
      valid = 6'(HalfPanel);
    end else begin
      valid = rem[5:0];
    end
    last_row   = ({1'b0, r} + 11'd1) >= {1'b0, cfg.rows};
    emits      = r[0] || last_row;
    k_even     = cfg.rows + {{(RowW-1){1'b0}}, cfg.rows[0]};
    product    = 23'(psc) * 23'(k_even);
    row_term   = wide ? {r[9:1], 6'b0} : {1'b0, r[9:1], 5'b0};
    col_sum    = {1'b0, psc} + (ColW+1)'(valid);
    last_panel = col_sum >= {1'b0, cfg.cols};
  end

  assign full     = job_full;
  assign accept   = push && !full;
  assign job_push = accept && emits;

  always_comb begin
    job.base = product[OfsW-1:0] + OfsW'(row_term);
    job.wide = wide;
    job.done = last_row && last_panel;
    for (int j = 0; j < PanelWidth; j++) begin
      if (6'(j) < valid) begin
        job.data[16*j +: 8]   = r[0] ? held_even_row[j] : row_bits[8*j +: 8];
        job.data[16*j+8 +: 8] = r[0] ? row_bits[8*j +: 8] : 8'h00;
      end else begin
        job.data[16*j +: 16]  = 16'h0000;
      end
    end
  end

  always_comb begin
    row_index_next       = row_index;
    panel_start_col_next = panel_start_col;
    if (cfg.restart) begin
      row_index_next       = '0;
      panel_start_col_next = '0;
    end else if (accept) begin
      if (last_row) begin
        row_index_next       = '0;
        panel_start_col_next = last_panel ? '0 : col_sum[ColW-1:0];
      end else begin
        row_index_next       = r + 10'd1;
        panel_start_col_next = psc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_index       <= '0;
      panel_start_col <= '0;
    end else begin
      row_index       <= row_index_next;
      panel_start_col <= panel_start_col_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !emits) begin
      held_even_row <= row_bits;
    end
  end

endmodule

// ----- hdl/gbpi_job_fifo.sv -----
`timescale 1ns / 1ps
// Two-entry queue of row-pair jobs between the front and the back end.
module gbpi_job_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  gbpi_pkg::job_t wr_job,
  output logic           full,
  input  logic           pop,
  output gbpi_pkg::job_t rd_job,
  output logic           valid
);
  import gbpi_pkg::*;

  job_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full   = count == 2'd2;
  assign valid  = count != 2'd0;
  assign rd_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_job;
    end
  end

endmodule

// ----- hdl/gbpi_back.sv -----
`timescale 1ns / 1ps
// Back end: steps through the chunks of each job into the output register.
module gbpi_back (
  input  logic                       clk,
  input  logic                       rst,
  input  gbpi_pkg::job_t             job,
  input  logic                       job_valid,
  output logic                       job_pop,
  input  logic                       pop,
  output logic                       empty,
  output logic [gbpi_pkg::OfsW-1:0]  dest_offset,
  output logic [gbpi_pkg::LaneW-1:0] chunk_low,
  output logic [gbpi_pkg::LaneW-1:0] chunk_high,
  output logic                       run_last,
  output logic                       matrix_done
);
  import gbpi_pkg::*;

  logic        out_valid;
  logic [1:0]  chunk_sel;
  logic        load;
  logic        last_chunk;
  logic [ChunkW-1:0] chunk;

  assign load       = job_valid && (!out_valid || pop);
  assign last_chunk = job.wide ? (chunk_sel == 2'd3) : (chunk_sel == 2'd1);
  assign job_pop    = load && last_chunk;
  assign empty      = !out_valid;
  assign chunk      = job.data[{chunk_sel, 7'b0} +: ChunkW];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      chunk_sel <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        chunk_sel <= last_chunk ? 2'd0 : chunk_sel + 2'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dest_offset <= job.base + OfsW'({chunk_sel, 4'b0});
      chunk_low   <= chunk[LaneW-1:0];
      chunk_high  <= chunk[ChunkW-1:LaneW];
      run_last    <= last_chunk;
      matrix_done <= last_chunk && job.done;
    end
  end

endmodule

// ----- hdl/gemm_b_pair_interleave_packer.sv -----
`timescale 1ns / 1ps
// Top level of the pair-interleave packer: register port, front end, job queue and back end.
// The first word of a row pair passes through the job queue and then the output register after the odd row is accepted.
// A 32-wide panel gives four words per row pair, a 16-wide panel two, one word a cycle while pop is held.
// In 32-wide panels the row rate is bounded by the single output register, which holds one word at a time.
// Rows are taken every cycle while the two-entry job queue has room.
// Reset sets row_count to 2, column_count to 32 and the position to row 0 of panel 0.
module gemm_b_pair_interleave_packer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       push,
  output logic                       full,
  input  logic [gbpi_pkg::LaneW-1:0] lane_bytes_0,
  input  logic [gbpi_pkg::LaneW-1:0] lane_bytes_1,
  input  logic [gbpi_pkg::LaneW-1:0] lane_bytes_2,
  input  logic [gbpi_pkg::LaneW-1:0] lane_bytes_3,
  output logic                       empty,
  input  logic                       pop,
  output logic [gbpi_pkg::OfsW-1:0]  dest_offset,
  output logic [gbpi_pkg::LaneW-1:0] chunk_low,
  output logic [gbpi_pkg::LaneW-1:0] chunk_high,
  output logic                       run_last,
  output logic                       matrix_done,
  output logic [6:0]                 packed_row_stride,
  output logic [5:0]                 packed_col_stride
);
  import gbpi_pkg::*;

  logic [RowW-1:0] row_count;
  logic [ColW-1:0] column_count;
  logic            cfg_write;
  cfg_t            cfg;
  job_t            front_job;
  job_t            queue_job;
  logic            job_push;
  logic            job_full;
  logic            job_pop;
  logic            job_valid;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= RowCountReset;
      column_count <= ColumnCountReset;
    end else if (cfg_write) begin
      case (paddr[2])
        RegRowCount:    row_count    <= pwdata[RowW-1:0];
        RegColumnCount: column_count <= pwdata[ColW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegRowCount:    prdata = 32'(row_count);
      RegColumnCount: prdata = 32'(column_count);
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    cfg.restart = cfg_write;
    if (row_count == '0) begin
      cfg.rows = RowW'(1);
    end else if (row_count > RowW'(MaxK)) begin
      cfg.rows = RowW'(MaxK);
    end else begin
      cfg.rows = row_count;
    end
    if (column_count == '0) begin
      cfg.cols = ColW'(1);
    end else if (column_count > ColW'(MaxN)) begin
      cfg.cols = ColW'(MaxN);
    end else begin
      cfg.cols = column_count;
    end
  end

  gbpi_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .push         (push),
    .full         (full),
    .lane_bytes_0 (lane_bytes_0),
    .lane_bytes_1 (lane_bytes_1),
    .lane_bytes_2 (lane_bytes_2),
    .lane_bytes_3 (lane_bytes_3),
    .job          (front_job),
    .job_push     (job_push),
    .job_full     (job_full)
  );

  gbpi_job_fifo u_job_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (job_push),
    .wr_job (front_job),
    .full   (job_full),
    .pop    (job_pop),
    .rd_job (queue_job),
    .valid  (job_valid)
  );

  gbpi_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job         (queue_job),
    .job_valid   (job_valid),
    .job_pop     (job_pop),
    .pop         (pop),
    .empty       (empty),
    .dest_offset (dest_offset),
    .chunk_low   (chunk_low),
    .chunk_high  (chunk_high),
    .run_last    (run_last),
    .matrix_done (matrix_done)
  );

  assign packed_row_stride = PackedRowStride;
  assign packed_col_stride = PackedColStride;

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the pair-interleave packer: a directed table, then random phases.
module testbench;
  import gbpi_pkg::*;

  typedef logic [3:0][LaneW-1:0] row_t;

  typedef struct {
    logic [OfsW-1:0]  ofs;
    logic [LaneW-1:0] lo;
    logic [LaneW-1:0] hi;
    logic             last;
    logic             done;
  } chunk_t;

  typedef struct {
    bit               is_cfg;
    logic [0:0]       reg_sel;
    logic [31:0]      value;
    row_t             lanes;
    bit               typed;
    logic [OfsW-1:0]  t_base;
    logic [LaneW-1:0] t_fill;
    int               t_n;
    bit               t_done;
  } step_t;

  logic             clk;
  logic             rst;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [2:0]       paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;
  logic             push;
  logic             full;
  logic [LaneW-1:0] lane_bytes_0;
  logic [LaneW-1:0] lane_bytes_1;
  logic [LaneW-1:0] lane_bytes_2;
  logic [LaneW-1:0] lane_bytes_3;
  logic             empty;
  logic             pop;
  logic [OfsW-1:0]  dest_offset;
  logic [LaneW-1:0] chunk_low;
  logic [LaneW-1:0] chunk_high;
  logic             run_last;
  logic             matrix_done;
  logic [6:0]       packed_row_stride;
  logic [5:0]       packed_col_stride;

  gemm_b_pair_interleave_packer dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .push(push), .full(full),
    .lane_bytes_0(lane_bytes_0), .lane_bytes_1(lane_bytes_1),
    .lane_bytes_2(lane_bytes_2), .lane_bytes_3(lane_bytes_3),
    .empty(empty), .pop(pop),
    .dest_offset(dest_offset), .chunk_low(chunk_low), .chunk_high(chunk_high),
    .run_last(run_last), .matrix_done(matrix_done),
    .packed_row_stride(packed_row_stride), .packed_col_stride(packed_col_stride)
  );

  chunk_t      chunk_q[$];
  step_t       row_tags[$];
  step_t       plan[$];
  int          errors;
  int          push_idle_pct;
  int          pop_stall_pct;
  int          hold_req;
  int          hold_left;

  logic [7:0]      held_row [PanelWidth];
  int unsigned     row_pos;
  int unsigned     panel_col;
  logic [RowW-1:0] cfg_rows;
  logic [ColW-1:0] cfg_cols;

  task automatic mismatch(input string msg);
    errors++;
    if (errors <= 40) $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  // Works out the packed words that one accepted row causes and appends them to chunk_q.
  task automatic pack_row(input row_t lanes);
    int unsigned rows, cols, k_even, rem, width, valid, base, nch;
    logic [7:0]  ev [PanelWidth];
    logic [7:0]  od [PanelWidth];
    logic [7:0]  b;
    bit          last_row, last_panel;
    chunk_t      ck;
    rows = cfg_rows;
    if (rows == 0) rows = 1;
    if (rows > MaxK) rows = MaxK;
    cols = cfg_cols;
    if (cols == 0) cols = 1;
    if (cols > MaxN) cols = MaxN;
    k_even = rows + (rows % 2);
    if (panel_col >= cols) panel_col = 0;
    if (row_pos >= rows) row_pos = 0;
    rem = cols - panel_col;
    if (rem >= PanelWidth) begin
      width = PanelWidth;
      valid = PanelWidth;
    end else if (rem >= HalfPanel) begin
      width = HalfPanel;
      valid = HalfPanel;
    end else begin
      width = HalfPanel;
      valid = rem;
    end
    last_row = (row_pos + 1 >= rows);
    if ((row_pos % 2) == 0 && !last_row) begin
      for (int i = 0; i < PanelWidth; i++) held_row[i] = lanes[i / 8][8 * (i % 8) +: 8];
      row_pos = row_pos + 1;
      return;
    end
    for (int i = 0; i < PanelWidth; i++) begin
      b = lanes[i / 8][8 * (i % 8) +: 8];
      if (i >= valid) begin
        ev[i] = 8'h00;
        od[i] = 8'h00;
      end else if (row_pos % 2) begin
        ev[i] = held_row[i];
        od[i] = b;
      end else begin
        ev[i] = b;
        od[i] = 8'h00;
      end
    end
    last_panel = (panel_col + valid >= cols);
    base = panel_col * k_even + (row_pos & ~32'd1) * width;
    nch = width / 8;
    for (int c = 0; c < nch; c++) begin
      ck.lo = '0;
      ck.hi = '0;
      for (int j = 0; j < 4; j++) begin
        ck.lo[16 * j +: 8]     = ev[8 * c + j];
        ck.lo[16 * j + 8 +: 8] = od[8 * c + j];
        ck.hi[16 * j +: 8]     = ev[8 * c + 4 + j];
        ck.hi[16 * j + 8 +: 8] = od[8 * c + 4 + j];
      end
      ck.ofs  = base + 16 * c;
      ck.last = (c + 1 == nch);
      ck.done = (c + 1 == nch) && last_row && last_panel;
      chunk_q.push_back(ck);
    end
    if (last_row) begin
      row_pos = 0;
      panel_col = panel_col + valid;
      if (panel_col >= cols) panel_col = 0;
    end else begin
      row_pos = row_pos + 1;
    end
  endtask

  always @(posedge clk) begin : monitor
    chunk_t want;
    step_t  tag;
    int     n0;
    if (rst) begin
      cfg_rows = RowCountReset;
      cfg_cols = ColumnCountReset;
      row_pos = 0;
      panel_col = 0;
      for (int i = 0; i < PanelWidth; i++) held_row[i] = 8'h00;
    end else begin
      if (pop && !empty) begin
        if (chunk_q.size() == 0) begin
          mismatch($sformatf("word at offset %h with nothing expected", dest_offset));
        end else begin
          want = chunk_q.pop_front();
          if (dest_offset !== want.ofs)
            mismatch($sformatf("dest_offset %h, want %h", dest_offset, want.ofs));
          if (chunk_low !== want.lo)
            mismatch($sformatf("chunk_low %h, want %h", chunk_low, want.lo));
          if (chunk_high !== want.hi)
            mismatch($sformatf("chunk_high %h, want %h", chunk_high, want.hi));
          if (run_last !== want.last)
            mismatch($sformatf("run_last %b, want %b", run_last, want.last));
          if (matrix_done !== want.done)
            mismatch($sformatf("matrix_done %b, want %b", matrix_done, want.done));
        end
        if (packed_row_stride !== PackedRowStride)
          mismatch($sformatf("packed_row_stride %0d", packed_row_stride));
        if (packed_col_stride !== PackedColStride)
          mismatch($sformatf("packed_col_stride %0d", packed_col_stride));
      end
      if (push && !full) begin
        tag.typed = 0;
        if (row_tags.size() != 0) tag = row_tags.pop_front();
        n0 = chunk_q.size();
        pack_row({lane_bytes_3, lane_bytes_2, lane_bytes_1, lane_bytes_0});
        if (tag.typed) begin
          while (chunk_q.size() > n0) void'(chunk_q.pop_back());
          for (int c = 0; c < tag.t_n; c++) begin
            want.ofs  = tag.t_base + 16 * c;
            want.lo   = tag.t_fill;
            want.hi   = tag.t_fill;
            want.last = (c + 1 == tag.t_n);
            want.done = (c + 1 == tag.t_n) && tag.t_done;
            chunk_q.push_back(want);
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2:2] == RegRowCount) cfg_rows = pwdata[RowW-1:0];
        else cfg_cols = pwdata[ColW-1:0];
        row_pos = 0;
        panel_col = 0;
      end
    end
  end

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("gemm_b_pair_interleave_packer verification failed");
    $finish;
  end

  initial begin
    pop <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= pop_stall_pct);
      end
    end
  end

  function automatic row_t random_row();
    row_t r;
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(19))
        0, 1, 2: r[i] = '0;
        3, 4, 5: r[i] = '1;
        default: r[i] = {$urandom, $urandom};
      endcase
    end
    return r;
  endfunction

  function automatic step_t cfg_step(input logic [0:0] sel, input logic [31:0] v);
    step_t s;
    s.is_cfg = 1;
    s.reg_sel = sel;
    s.value = v;
    s.typed = 0;
    return s;
  endfunction

  function automatic step_t row_step(input row_t lanes, input bit typed,
                                     input logic [OfsW-1:0] base,
                                     input logic [LaneW-1:0] fill, input int n,
                                     input bit done);
    step_t s;
    s.is_cfg = 0;
    s.lanes = lanes;
    s.typed = typed;
    s.t_base = base;
    s.t_fill = fill;
    s.t_n = n;
    s.t_done = done;
    return s;
  endfunction

  task automatic send_row(input step_t s);
    while ($urandom_range(99) < push_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    row_tags.push_back(s);
    push <= 1'b1;
    lane_bytes_0 <= s.lanes[0];
    lane_bytes_1 <= s.lanes[1];
    lane_bytes_2 <= s.lanes[2];
    lane_bytes_3 <= s.lanes[3];
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Stops offering rows and lets the block drain, so that registers change only while it is idle.
  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (chunk_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic reg_write(input logic [0:0] sel, input logic [31:0] value);
    logic [31:0] rd;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (sel == RegRowCount) begin
      if (rd[RowW-1:0] !== value[RowW-1:0])
        mismatch($sformatf("row_count reads %h, want %h", rd, value[RowW-1:0]));
    end else begin
      if (rd[ColW-1:0] !== value[ColW-1:0])
        mismatch($sformatf("column_count reads %h, want %h", rd, value[ColW-1:0]));
    end
  endtask

  initial begin
    logic [31:0] rows_v, cols_v;
    int          mode;
    errors = 0;
    hold_req = 0;
    push_idle_pct = 0;
    pop_stall_pct = 0;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    push <= 1'b0;
    lane_bytes_0 <= '0;
    lane_bytes_1 <= '0;
    lane_bytes_2 <= '0;
    lane_bytes_3 <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings first: two rows, one full panel, so every word reads off directly.
    plan.push_back(row_step('1, 1, 0, 0, 0, 0));
    plan.push_back(row_step('1, 1, 0, '1, 4, 1));
    plan.push_back(row_step('0, 1, 0, 0, 0, 0));
    plan.push_back(row_step('0, 1, 0, '0, 4, 1));
    // A single row in a half panel is emitted at once against a zero odd row.
    plan.push_back(cfg_step(RegRowCount, 32'd1));
    plan.push_back(cfg_step(RegColumnCount, 32'd16));
    plan.push_back(row_step('0, 1, 0, '0, 2, 1));
    plan.push_back(row_step('1, 0, 0, 0, 0, 0));
    plan.push_back(row_step(random_row(), 0, 0, 0, 0, 0));
    // Zero in both registers behaves as one row by one column.
    plan.push_back(cfg_step(RegRowCount, 32'd0));
    plan.push_back(cfg_step(RegColumnCount, 32'd0));
    plan.push_back(row_step(random_row(), 0, 0, 0, 0, 0));
    plan.push_back(row_step('1, 0, 0, 0, 0, 0));
    // Odd row count with a full panel followed by a half panel.
    plan.push_back(cfg_step(RegRowCount, 32'd3));
    plan.push_back(cfg_step(RegColumnCount, 32'd48));
    for (int i = 0; i < 6; i++) plan.push_back(row_step(random_row(), 0, 0, 0, 0, 0));
    // A fringe of eight columns forms a zero-filled half panel.
    plan.push_back(cfg_step(RegRowCount, 32'd2));
    plan.push_back(cfg_step(RegColumnCount, 32'd40));
    for (int i = 0; i < 4; i++) plan.push_back(row_step(random_row(), 0, 0, 0, 0, 0));
    // Register maxima saturate to the largest matrix.
    plan.push_back(cfg_step(RegRowCount, 32'hffff_ffff));
    plan.push_back(cfg_step(RegColumnCount, 32'hffff_ffff));
    for (int i = 0; i < 4; i++) plan.push_back(row_step(random_row(), 0, 0, 0, 0, 0));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        reg_write(plan[i].reg_sel, plan[i].value);
      end else begin
        send_row(plan[i]);
      end
    end

    for (int phase = 0; phase < 8; phase++) begin
      mode = phase % 4;
      case ($urandom_range(9))
        0: rows_v = MaxK;
        1: rows_v = 0;
        2: rows_v = 1023;
        3: rows_v = 1;
        default: rows_v = $urandom_range(2, 6);
      endcase
      case ($urandom_range(9))
        0: cols_v = MaxN;
        1: cols_v = 0;
        2: cols_v = 8191;
        3: cols_v = $urandom_range(1, 15);
        default: cols_v = $urandom_range(16, 100);
      endcase
      if ($urandom_range(1)) rows_v = rows_v | ($urandom & ~32'h3ff);
      if ($urandom_range(1)) cols_v = cols_v | ($urandom & ~32'h1fff);
      settle();
      if ($urandom_range(1)) begin
        reg_write(RegRowCount, rows_v);
        reg_write(RegColumnCount, cols_v);
      end else begin
        reg_write(RegColumnCount, cols_v);
        reg_write(RegRowCount, rows_v);
      end
      push_idle_pct = (mode == 1) ? 85 : (mode == 3) ? 14 : 0;
      pop_stall_pct = (mode == 2) ? 85 : (mode == 3) ? 14 : 0;
      if (phase == 4) hold_req = 200;
      for (int i = 0; i < 14; i++) begin
        if (phase == 6 && i == 8) begin
          push <= 1'b0;
          @(posedge clk);
          while (chunk_q.size() != 0) @(posedge clk);
        end
        send_row(row_step(random_row(), 0, 0, 0, 0, 0));
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (chunk_q.size() != 0) mismatch($sformatf("%0d words never arrived", chunk_q.size()));
    if (errors == 0) begin
      $display("gemm_b_pair_interleave_packer verification clean");
    end else begin
      $display("gemm_b_pair_interleave_packer verification failed");
    end
    $finish;
  end

endmodule
